// File: rtl/command_frame_parser_top_macros.svh
// assertion macros used by the frame parser top
`ifndef COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define COMMAND_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CFP_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("frame parser check failed");

// next-cycle implication, checked outside reset
`define CFP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("frame parser check failed");

`endif

// File: rtl/cfp_pkg.sv
// types and constants of the command frame parser
package cfp_pkg;

   localparam int BUFFER_BYTES = 64;
   localparam int MAX_LEN      = BUFFER_BYTES - 3;
   localparam int LEFT_W       = $clog2(MAX_LEN);

   localparam logic [7:0] HEADER_BYTE = 8'h3e;
   localparam logic [2:0] ARG_OFFSET  = 3'd3;
   localparam logic [2:0] POS_MAX     = 3'd4;
   localparam logic [7:0] CMD_LIMIT_RESET = 8'd5;

   // parser phases
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CSUM = 3'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_in_chunk;
   } req_type;

   typedef struct packed {
      logic       checksum_ok;
      logic [7:0] command;
      logic [5:0] payload_len;
      logic [7:0] first_arg;
   } rsp_type;

   typedef struct packed {
      logic produce;
      logic hunting;
   } cfp_status_type;

endpackage

// File: rtl/cfp_core.sv
// frame parser state machine with running checksum
module cfp_core import cfp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   input  logic [7:0]     command_limit,
   output cfp_status_type status,
   output rsp_type        result
);

   logic [2:0]        phase_ff, phase_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [5:0]        len_ff, len_in;
   logic [7:0]        arg_ff, arg_in;
   logic [2:0]        pos_ff, pos_in;

   logic [7:0] sum_take;
   logic [7:0] arg_take;
   logic [2:0] pos_take;

   assign sum_take = sum_ff + rx_byte;
   assign arg_take = (pos_ff == ARG_OFFSET) ? rx_byte : arg_ff;
   assign pos_take = (pos_ff < POS_MAX) ? pos_ff + 3'd1 : pos_ff;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      sum_in   = sum_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      arg_in   = arg_ff;
      pos_in   = pos_ff;
      unique case (phase_ff)
         PH_CMD: begin
            sum_in   = sum_take;
            arg_in   = arg_take;
            pos_in   = pos_take;
            cmd_in   = rx_byte;
            phase_in = (rx_byte < command_limit) ? PH_LEN : PH_HUNT;
         end
         PH_LEN: begin
            sum_in = sum_take;
            arg_in = arg_take;
            pos_in = pos_take;
            len_in = rx_byte[5:0];
            if (rx_byte == 8'd0) begin
               phase_in = PH_CSUM;
            end else if ({1'b0, rx_byte} < 9'(MAX_LEN)) begin
               left_in  = rx_byte[LEFT_W-1:0];
               phase_in = PH_DATA;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_DATA: begin
            sum_in  = sum_take;
            arg_in  = arg_take;
            pos_in  = pos_take;
            left_in = left_ff - LEFT_W'(1);
            if (left_ff == LEFT_W'(1)) begin
               phase_in = PH_CSUM;
            end
         end
         PH_CSUM: begin
            sum_in   = sum_take;
            arg_in   = arg_take;
            pos_in   = pos_take;
            phase_in = PH_HUNT;
         end
         default: begin
            // header hunt; unused codes land here too
            if (rx_byte == HEADER_BYTE) begin
               sum_in   = rx_byte;
               pos_in   = 3'd1;
               phase_in = PH_CMD;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         left_ff  <= '0;
         sum_ff   <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         arg_ff   <= '0;
         pos_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         sum_ff   <= sum_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         arg_ff   <= arg_in;
         pos_ff   <= pos_in;
      end
   end

   assign status.produce = (phase_ff == PH_CSUM);
   assign status.hunting = (phase_ff != PH_CMD) && (phase_ff != PH_LEN) &&
                           (phase_ff != PH_DATA) && (phase_ff != PH_CSUM);

   assign result.checksum_ok = (sum_take == 8'd0);
   assign result.command     = cmd_ff;
   assign result.payload_len = len_ff;
   assign result.first_arg   = arg_take;

endmodule

// File: rtl/command_frame_parser_top.sv
// top level of the command frame parser
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_ready   | req_item (req_type)
//   rsp     | out       | rsp_valid / rsp_ready   | rsp_item (rsp_type)
//   csr     | in        | csr_wr_en               | csr_wr_data (command limit)
//
// one byte per cycle sustained unless a checksum byte waits on a stalled result;
// each byte is held in the input register, the parser state advances as it leaves,
// and a result is loaded into the output register as the checksum byte leaves.
// reset is synchronous and puts the parser in header hunt with a limit of 5.
// a stalled result only holds back a checksum byte; other bytes keep flowing.
`include "command_frame_parser_top_macros.svh"

module command_frame_parser_top import cfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_item,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0]     limit_ff;
   logic           in_valid_ff;
   req_type        in_item_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_item_ff;

   logic           step;
   logic           load;
   cfp_status_type status;
   rsp_type        result;

   cfp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .rx_byte       (in_item_ff.rx_byte),
      .command_limit (limit_ff),
      .status        (status),
      .result        (result)
   );

   // a checksum byte waits until the output register is free
   assign step      = in_valid_ff && (!status.produce || !rsp_valid_ff || rsp_ready);
   assign load      = step && status.produce;
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CMD_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `CFP_ASSERT_IMP(a_load_free, clock, reset, load, !rsp_valid_ff || rsp_ready)
   `CFP_ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_valid_ff)
   `CFP_ASSERT_NEXT(a_csum_hunt, clock, reset, load, status.hunting)
   `CFP_ASSERT_IMP(a_stall_full, clock, reset, !req_ready, in_valid_ff && status.produce)

endmodule
